>>> rtl/ked_pkg.sv
package ked_pkg;

   // Held-key table size and derived index width
   localparam int HELD_SLOTS = 6;
   localparam int SLOT_W     = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

   // Zero-based key numbers with special meaning
   localparam logic [6:0] KEY_SYM   = 7'h14;
   localparam logic [6:0] KEY_CAPS  = 7'h1C;
   localparam logic [6:0] KEY_BKSP  = 7'h1D;
   localparam logic [6:0] KEY_SPACE = 7'h1E;

   // Fixed character codes
   localparam logic [7:0] CHAR_NONE  = 8'h00;
   localparam logic [7:0] CHAR_BKSP  = 8'h08;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   // Key matrix: 4 rows of 10 columns
   localparam int MAP_KEYS = 40;

   // Configuration register map
   localparam int CFG_INDEX_W = 2;
   localparam int CFG_DATA_W  = 16;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CFG_ENABLE   = 2'd0,
      CFG_DELAY    = 2'd1,
      CFG_INTERVAL = 2'd2
   } cfg_reg_type;

   localparam logic [15:0] DELAY_RESET    = 16'd420;
   localparam logic [15:0] INTERVAL_RESET = 16'd55;

   localparam logic [7:0] BASE_MAP [0:MAP_KEYS-1] = '{
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h0A,
      8'h00, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h00, 8'h00,
      8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] SYM_MAP [0:MAP_KEYS-1] = '{
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h2A, 8'h2F, 8'h2B, 8'h2D, 8'h3D, 8'h3A, 8'h27, 8'h22, 8'h40, 8'h00,
      8'h00, 8'h5F, 8'h24, 8'h3B, 8'h3F, 8'h21, 8'h2C, 8'h2E, 8'h00, 8'h00,
      8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Map a zero-based key through the active layer; 0 means no character
   function automatic logic [7:0] map_key(input logic [6:0] k,
                                          input logic       sym,
                                          input logic       caps);
      logic [7:0] v;
      logic [5:0] idx;
      v   = CHAR_NONE;
      idx = k[5:0];
      if (k < 7'(MAP_KEYS)) begin
         if (sym) begin
            v = SYM_MAP[idx];
         end else begin
            v = BASE_MAP[idx];
            if (caps && (v inside {[8'h61:8'h7A]})) begin
               v = v - CASE_SHIFT;
            end
         end
      end
      return v;
   endfunction

endpackage

>>> rtl/ked_req_if.sv
interface ked_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  event_code;
   logic [31:0] now_ms;

   modport source (output valid, output cmd, output event_code, output now_ms,
                   input ready);
   modport sink   (input valid, input cmd, input event_code, input now_ms,
                   output ready);
endinterface

>>> rtl/ked_rsp_if.sv
interface ked_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_char;
   logic       char_valid;

   modport source (output valid, output key_char, output char_valid, input ready);
   modport sink   (input valid, input key_char, input char_valid, output ready);
endinterface

>>> rtl/ked_csr_if.sv
interface ked_csr_if
   import ked_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [CFG_INDEX_W-1:0] index;
   logic [CFG_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/keyboard_event_decoder_with_repeat.sv
// A beat accepted on req sits in the input register; its result then moves to the result
// register and is held on rsp until taken.
// Throughput: one beat per cycle while rsp is ready; a stalled result holds back at most
// one more beat in the input register. Configuration writes are always ready.
// Reset (synchronous, active high) empties both registers, releases Sym and Caps,
// disarms every held slot and loads enable 1, delay 420 ms, interval 55 ms.
module keyboard_event_decoder_with_repeat
   import ked_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   ked_req_if.sink   req,
   ked_rsp_if.source rsp,
   ked_csr_if.sink   csr
);

   // Configuration registers
   logic        enable_ff, enable_in;
   logic [15:0] delay_ff, delay_in;
   logic [15:0] interval_ff, interval_in;

   // Modifier state
   logic sym_ff, sym_in;
   logic caps_ff, caps_in;

   // Held-key table
   logic [HELD_SLOTS-1:0] slot_active_ff, slot_active_in;
   logic [6:0]  slot_key_ff   [HELD_SLOTS], slot_key_in   [HELD_SLOTS];
   logic [7:0]  slot_char_ff  [HELD_SLOTS], slot_char_in  [HELD_SLOTS];
   logic [31:0] slot_start_ff [HELD_SLOTS], slot_start_in [HELD_SLOTS];
   logic [31:0] slot_last_ff  [HELD_SLOTS], slot_last_in  [HELD_SLOTS];

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff, in_cmd_in;
   logic [7:0]  in_code_ff, in_code_in;
   logic [31:0] in_now_ff, in_now_in;

   // Result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_cvalid_ff, out_cvalid_in;

   // Decode
   logic        advance;
   logic        is_event;
   logic        pressed;
   logic [6:0]  key;
   logic [7:0]  press_char;
   logic [7:0]  ch;

   // Slot searches
   logic              match_hit, free_hit, due_hit;
   logic [SLOT_W-1:0] match_idx, free_idx, evict_idx, due_idx, load_idx;

   // Handshakes
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   assign rsp.valid      = out_valid_ff;
   assign rsp.key_char   = out_char_ff;
   assign rsp.char_valid = out_cvalid_ff;

   // Decode the held beat
   assign key      = in_code_ff[6:0] - 7'd1;
   assign pressed  = in_code_ff[7];
   assign is_event = in_cmd_ff && (in_code_ff[6:0] != 7'd0);

   always_comb begin
      case (key)
         KEY_SPACE: press_char = CHAR_SPACE;
         KEY_BKSP:  press_char = CHAR_BKSP;
         default:   press_char = map_key(key, sym_ff, caps_ff);
      endcase
   end

   // Find an armed slot already holding this key
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = 0; i < HELD_SLOTS; i++) begin
         if (!match_hit && slot_active_ff[i] && (slot_key_ff[i] == key)) begin
            match_hit = 1'b1;
            match_idx = SLOT_W'(i);
         end
      end
   end

   // Find the first free slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = 0; i < HELD_SLOTS; i++) begin
         if (!free_hit && !slot_active_ff[i]) begin
            free_hit = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // Pick the earliest start time for eviction, lowest index on a tie
   always_comb begin
      evict_idx = '0;
      for (int i = 1; i < HELD_SLOTS; i++) begin
         if (slot_start_ff[i] < slot_start_ff[evict_idx]) begin
            evict_idx = SLOT_W'(i);
         end
      end
   end

   assign load_idx = free_hit ? free_idx : evict_idx;

   // Find the first slot due to repeat
   always_comb begin
      logic [31:0] held_for;
      logic [31:0] since_last;
      due_hit    = 1'b0;
      due_idx    = '0;
      held_for   = '0;
      since_last = '0;
      for (int i = 0; i < HELD_SLOTS; i++) begin
         held_for   = in_now_ff - slot_start_ff[i];
         since_last = in_now_ff - slot_last_ff[i];
         if (!due_hit && slot_active_ff[i] &&
             (held_for >= {16'd0, delay_ff}) &&
             (since_last >= {16'd0, interval_ff})) begin
            due_hit = 1'b1;
            due_idx = SLOT_W'(i);
         end
      end
   end

   // Next state of the decoder and the held-key table
   always_comb begin
      sym_in         = sym_ff;
      caps_in        = caps_ff;
      slot_active_in = slot_active_ff;
      slot_key_in    = slot_key_ff;
      slot_char_in   = slot_char_ff;
      slot_start_in  = slot_start_ff;
      slot_last_in   = slot_last_ff;
      ch             = CHAR_NONE;

      if (advance && enable_ff) begin
         if (is_event) begin
            if (key == KEY_SYM) begin
               sym_in = pressed;
            end else if (key == KEY_CAPS) begin
               caps_in = pressed;
            end else if (!pressed) begin
               // drop every armed slot for this key
               for (int i = 0; i < HELD_SLOTS; i++) begin
                  if (slot_active_ff[i] && (slot_key_ff[i] == key)) begin
                     slot_active_in[i] = 1'b0;
                  end
               end
            end else begin
               ch = press_char;
               if (press_char != CHAR_NONE) begin
                  if (match_hit) begin
                     // restart timing, keep the stored character
                     slot_start_in[match_idx] = in_now_ff;
                     slot_last_in[match_idx]  = in_now_ff;
                  end else begin
                     slot_active_in[load_idx] = 1'b1;
                     slot_key_in[load_idx]    = key;
                     slot_char_in[load_idx]   = press_char;
                     slot_start_in[load_idx]  = in_now_ff;
                     slot_last_in[load_idx]   = in_now_ff;
                  end
               end
            end
         end else if (due_hit) begin
            slot_last_in[due_idx] = in_now_ff;
            ch = slot_char_ff[due_idx];
         end
      end

      // A delay write disarms the whole table
      if (csr.valid && (csr.index == CFG_DELAY)) begin
         slot_active_in = '0;
      end
   end

   // Configuration writes
   always_comb begin
      enable_in   = enable_ff;
      delay_in    = delay_ff;
      interval_in = interval_ff;
      if (csr.valid) begin
         case (csr.index)
            CFG_ENABLE:   enable_in   = csr.data[0];
            CFG_DELAY:    delay_in    = csr.data;
            CFG_INTERVAL: interval_in = csr.data;
            default:      enable_in   = enable_ff;
         endcase
      end
   end

   // Input register: load on accept, empty when the beat moves on
   always_comb begin
      in_valid_in = in_valid_ff;
      in_cmd_in   = in_cmd_ff;
      in_code_in  = in_code_ff;
      in_now_in   = in_now_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_cmd_in   = req.cmd;
         in_code_in  = req.event_code;
         in_now_in   = req.now_ms;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: hold until taken
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_cvalid_in = out_cvalid_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_char_in   = ch;
         out_cvalid_in = (ch != CHAR_NONE);
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b1;
         delay_ff       <= DELAY_RESET;
         interval_ff    <= INTERVAL_RESET;
         sym_ff         <= 1'b0;
         caps_ff        <= 1'b0;
         slot_active_ff <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         enable_ff      <= enable_in;
         delay_ff       <= delay_in;
         interval_ff    <= interval_in;
         sym_ff         <= sym_in;
         caps_ff        <= caps_in;
         slot_active_ff <= slot_active_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      slot_key_ff   <= slot_key_in;
      slot_char_ff  <= slot_char_in;
      slot_start_ff <= slot_start_in;
      slot_last_ff  <= slot_last_in;
      in_cmd_ff     <= in_cmd_in;
      in_code_ff    <= in_code_in;
      in_now_ff     <= in_now_in;
      out_char_ff   <= out_char_in;
      out_cvalid_ff <= out_cvalid_in;
   end

endmodule
